FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the matrix multiply checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/core/mmu_pkg.sv
// ----------------------------------------------------------------------------
// mmu_pkg
// Types, codes and helpers shared by the matrix multiply unit.
// ----------------------------------------------------------------------------
package mmu_pkg;

    // Largest supported matrix dimension
    localparam int MAX_DIM_DEF = 8;

    // Size register width and reset value
    localparam int          DIM_W     = 4;
    localparam logic [3:0]  DIM_RESET = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROWS_A = 2'd0;
    localparam logic [1:0] CFG_INNER  = 2'd1;
    localparam logic [1:0] CFG_COLS_B = 2'd2;

    // Request codes
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [39:0] dot_value;
        logic               last;
    } rsp_t;

    // Per-step control from the sequencer to the MAC datapath
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       fin;
        logic       last;
        logic [2:0] row;
        logic [2:0] col;
    } tag_t;

    // Map a size register onto 1..limit
    function automatic logic [3:0] clamp_dim(input logic [3:0] v, input logic [3:0] limit);
        logic [3:0] r;
        begin
            r = v;
            if (v == 4'd0)
            begin
                r = 4'd1;
            end
            else if (v > limit)
            begin
                r = limit;
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/mmu_ram.sv
// ----------------------------------------------------------------------------
// mmu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mmu_seq.sv
// ----------------------------------------------------------------------------
// mmu_seq
// Loop sequencer: walks row, column and inner index, one MAC step a cycle.
// ----------------------------------------------------------------------------
module mmu_seq #(
    parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF,
    localparam int IdxW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int AddrW  = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               launch,
    input  logic [IdxW-1:0]    last_row,
    input  logic [IdxW-1:0]    last_inner,
    input  logic [IdxW-1:0]    last_col,
    output logic [AddrW-1:0]   a_addr,
    output logic [AddrW-1:0]   b_addr,
    output mmu_pkg::tag_t      tag
);

    logic            run_reg, run_next;
    logic [IdxW-1:0] i_reg, i_next;
    logic [IdxW-1:0] j_reg, j_next;
    logic [IdxW-1:0] k_reg, k_next;
    logic [IdxW-1:0] nr_reg, nr_next;
    logic [IdxW-1:0] nk_reg, nk_next;
    logic [IdxW-1:0] nc_reg, nc_next;

    // Describe the current step
    always_comb
    begin
        tag.valid = run_reg;
        tag.first = (k_reg == '0);
        tag.fin   = (k_reg == nk_reg);
        tag.last  = (k_reg == nk_reg) && (j_reg == nc_reg) && (i_reg == nr_reg);
        tag.row   = 3'(i_reg);
        tag.col   = 3'(j_reg);
        a_addr    = AddrW'(i_reg) * AddrW'(MAX_DIM) + AddrW'(k_reg);
        b_addr    = AddrW'(k_reg) * AddrW'(MAX_DIM) + AddrW'(j_reg);
    end

    // Advance inner, then column, then row
    always_comb
    begin
        run_next = run_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        nr_next  = nr_reg;
        nk_next  = nk_reg;
        nc_next  = nc_reg;
        if (launch)
        begin
            run_next = 1'b1;
            i_next   = '0;
            j_next   = '0;
            k_next   = '0;
            nr_next  = last_row;
            nk_next  = last_inner;
            nc_next  = last_col;
        end
        else if (run_reg)
        begin
            if (k_reg != nk_reg)
            begin
                k_next = k_reg + 1'b1;
            end
            else
            begin
                k_next = '0;
                if (j_reg != nc_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    j_next = '0;
                    if (i_reg != nr_reg)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        run_next = 1'b0;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
        end
        else
        begin
            run_reg <= run_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
            k_reg   <= k_next;
        end
    end

    // Latched sizes
    always_ff @(posedge clk)
    begin
        nr_reg <= nr_next;
        nk_reg <= nk_next;
        nc_reg <= nc_next;
    end

endmodule

FILE: rtl/core/mmu_mac.sv
// ----------------------------------------------------------------------------
// mmu_mac
// Shared multiply-accumulate unit: one 16x16 product a cycle into a
// 40-bit accumulator, with the finished dot product registered out.
// ----------------------------------------------------------------------------
module mmu_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  mmu_pkg::tag_t       tag_in,
    input  logic signed [15:0]  a_data,
    input  logic signed [15:0]  b_data,
    output mmu_pkg::rsp_t       result,
    output logic                result_valid,
    output logic                done
);

    mmu_pkg::tag_t      tag1_reg;
    mmu_pkg::tag_t      tag2_reg;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [39:0] acc_reg, acc_next;
    mmu_pkg::rsp_t      result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    // Multiply the operands read for the previous step
    assign prod_next = a_data * b_data;

    // Restart or extend the running sum
    always_comb
    begin
        if (tag2_reg.first)
        begin
            acc_next = 40'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + 40'(prod_reg);
        end
    end

    // Emit the sum on the final inner step
    always_comb
    begin
        result_valid_next     = tag2_reg.valid && tag2_reg.fin;
        result_next.out_row   = tag2_reg.row;
        result_next.out_col   = tag2_reg.col;
        result_next.dot_value = acc_next;
        result_next.last      = tag2_reg.last;
    end

    // Step tags and output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg         <= '0;
            tag2_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tag1_reg         <= tag_in;
            tag2_reg         <= tag1_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (result_valid_next)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign done         = tag2_reg.valid && tag2_reg.fin && tag2_reg.last;

endmodule

FILE: rtl/core/matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_unit
// Loads matrices A and B element by element and streams out A*B.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat (request) is taken at a rising edge with start high and
//   busy low. A load beat writes one element of A or B in that cycle and
//   produces no result; loads may follow each other every cycle.
//   A start beat raises busy and runs the product: one shared multiplier
//   and accumulator do one inner step per cycle. Each step passes through
//   the registered store read, the product register and the accumulator,
//   and each finished sum is registered out. Results come in row-major
//   order; last marks the final one. busy falls on the edge that shows
//   the last result.
//   Results are shown for one cycle on result with result_valid high; the
//   receiver cannot stall, so no result is held back.
//   Size registers are written through cfg_we/cfg_index/cfg_data while busy
//   is low; a size of 0 acts as 1 and one above MAX_DIM acts as MAX_DIM.
//   Reset clears busy and the pipeline and sets all sizes to 8; element
//   stores are undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_multiply_unit #(
    parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mmu_pkg::req_t                request,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [mmu_pkg::DIM_W-1:0]    cfg_data,
    output mmu_pkg::rsp_t                result,
    output logic                         result_valid
);

    localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int Depth = MAX_DIM * MAX_DIM;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

    logic [3:0]         rows_a_reg, inner_reg, cols_b_reg;
    logic               busy_reg, busy_next;
    logic               accept, launch, in_range, load_a, load_b, done;
    logic [AddrW-1:0]   waddr, a_addr, b_addr;
    logic [15:0]        a_rdata, b_rdata;
    logic [IdxW-1:0]    last_row, last_inner, last_col;
    mmu_pkg::tag_t      tag;

    // Decode the input beat
    always_comb
    begin
        accept   = start && !busy_reg;
        in_range = (4'(request.row) < 4'(MAX_DIM)) && (4'(request.col) < 4'(MAX_DIM));
        launch   = accept && (request.req_type == mmu_pkg::REQ_START);
        load_a   = accept && in_range && (request.req_type == mmu_pkg::REQ_LOAD_A);
        load_b   = accept && in_range && (request.req_type == mmu_pkg::REQ_LOAD_B);
        waddr    = AddrW'(request.row) * AddrW'(MAX_DIM) + AddrW'(request.col);
    end

    // Clamp sizes to last indexes for the sequencer
    always_comb
    begin
        last_row   = IdxW'(mmu_pkg::clamp_dim(rows_a_reg, 4'(MAX_DIM)) - 4'd1);
        last_inner = IdxW'(mmu_pkg::clamp_dim(inner_reg, 4'(MAX_DIM)) - 4'd1);
        last_col   = IdxW'(mmu_pkg::clamp_dim(cols_b_reg, 4'(MAX_DIM)) - 4'd1);
    end

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= mmu_pkg::DIM_RESET;
            inner_reg  <= mmu_pkg::DIM_RESET;
            cols_b_reg <= mmu_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mmu_pkg::CFG_ROWS_A: rows_a_reg <= cfg_data;
                mmu_pkg::CFG_INNER:  inner_reg  <= cfg_data;
                mmu_pkg::CFG_COLS_B: cols_b_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Hold busy from start until the last result
    always_comb
    begin
        busy_next = busy_reg;
        if (launch)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

    // Element stores
    mmu_ram #(
        .WIDTH (16),
        .DEPTH (Depth)
    ) u_store_a (
        .clk   (clk),
        .we    (load_a),
        .waddr (waddr),
        .wdata (request.value),
        .raddr (a_addr),
        .rdata (a_rdata)
    );

    mmu_ram #(
        .WIDTH (16),
        .DEPTH (Depth)
    ) u_store_b (
        .clk   (clk),
        .we    (load_b),
        .waddr (waddr),
        .wdata (request.value),
        .raddr (b_addr),
        .rdata (b_rdata)
    );

    // Loop sequencer
    mmu_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .launch     (launch),
        .last_row   (last_row),
        .last_inner (last_inner),
        .last_col   (last_col),
        .a_addr     (a_addr),
        .b_addr     (b_addr),
        .tag        (tag)
    );

    // Shared multiply-accumulate unit
    mmu_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag_in       (tag),
        .a_data       ($signed(a_rdata)),
        .b_data       ($signed(b_rdata)),
        .result       (result),
        .result_valid (result_valid),
        .done         (done)
    );

endmodule

FILE: rtl/core/mmu_check.sv
// ----------------------------------------------------------------------------
// mmu_check
// Port-level checker for the matrix multiply unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmu_check (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input mmu_pkg::req_t request,
    input mmu_pkg::rsp_t result,
    input logic          result_valid
);

    logic start_beat;
    logic load_beat;

    assign start_beat = start && !busy && (request.req_type == mmu_pkg::REQ_START);
    assign load_beat  = start && !busy && (request.req_type != mmu_pkg::REQ_START);

    // A start beat raises busy in the next cycle
    `ASSERT_ALWAYS(a_start_busy, clk, rst_n, start_beat |=> busy, "busy not raised after start")

    // Only the final result may show while busy is low
    `ASSERT_NEVER(a_early_idle, clk, rst_n, result_valid && !result.last && !busy, "result while idle")

    // busy drops only together with the last result
    `ASSERT_ALWAYS(a_busy_fall, clk, rst_n, $fell(busy) |-> (result_valid && result.last), "busy fell without last result")

    // Nothing follows the last result directly
    `ASSERT_ALWAYS(a_last_gap, clk, rst_n, (result_valid && result.last) |=> !result_valid, "result after last")

    // A load beat causes no result
    `ASSERT_ALWAYS(a_load_quiet, clk, rst_n, load_beat |=> !result_valid, "result after load beat")

endmodule

bind matrix_multiply_unit mmu_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result       (result),
    .result_valid (result_valid)
);
